// ===== rtl/rwg_pkg.sv =====
// Package for the RMS weighted greyscale block: widths, register codes,
// reset weights and the square-root step function.
// No dependencies.
package rwg_pkg;

    localparam int PIX_W       = 8;
    localparam int WEIGHT_W    = 17;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int PROD_W      = WEIGHT_W + SQ_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_W      = 16;
    localparam int VALUE_W     = 2 * PIX_W;
    localparam int REM_W       = PIX_W + 3;
    localparam int ROOT_STEPS  = 2;
    localparam int ROOT_STAGES = PIX_W / ROOT_STEPS;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_WEIGHT_RED   = 2'd0;
    localparam logic [1:0] REG_WEIGHT_GREEN = 2'd1;
    localparam logic [1:0] REG_WEIGHT_BLUE  = 2'd2;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED   = 17'd19595;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN = 17'd38470;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE  = 17'd7471;

    localparam logic [PIX_W-1:0] GREY_MAX = '1;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [PIX_W-1:0]   q;
        logic [VALUE_W-1:0] x;
    } t_root;

    // one restoring step: bring down two bits, try (4q + 1)
    function automatic t_root root_step(input t_root st);
        t_root            res;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {st.rem[REM_W-3:0], st.x[VALUE_W-1 -: 2]};
        trial = {1'b0, st.q, 2'b01};
        res.x = {st.x[VALUE_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            res.rem = rem2 - trial;
            res.q   = {st.q[PIX_W-2:0], 1'b1};
        end else begin
            res.rem = rem2;
            res.q   = {st.q[PIX_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/rwg_if.sv =====
// Stream interfaces of the greyscale block: RGB pixel words in, grey words out.
// Depends on rwg_pkg.
interface rwg_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rwg_pkg::PIX_W-1:0] red;
    logic [rwg_pkg::PIX_W-1:0] green;
    logic [rwg_pkg::PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rwg_grey_if;
    logic                      valid;
    logic                      ready;
    logic [rwg_pkg::PIX_W-1:0] grey;

    modport source (output valid, grey, input ready);
    modport sink   (input valid, grey, output ready);
endinterface

// ===== rtl/rwg_root.sv =====
// Pipelined integer square root of a 16-bit value, two root bits per stage,
// with saturation of the result. Depends on rwg_pkg.
module rwg_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rwg_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_sat,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rwg_pkg::PIX_W-1:0]   o_grey
);

    localparam int LAST = rwg_pkg::ROOT_STAGES - 1;

    logic [LAST:0]  r_v;
    logic [LAST:0]  r_sat;
    rwg_pkg::t_root r_st [rwg_pkg::ROOT_STAGES];

    logic [LAST:0]  w_rdy;
    logic [LAST:0]  w_src_v;
    logic [LAST:0]  w_src_sat;
    rwg_pkg::t_root w_src [rwg_pkg::ROOT_STAGES];
    rwg_pkg::t_root n_st  [rwg_pkg::ROOT_STAGES];

    always_comb begin
        w_src[0]     = '{rem: '0, q: '0, x: i_value};
        w_src_v[0]   = i_valid;
        w_src_sat[0] = i_sat;
        for (int s = 1; s < rwg_pkg::ROOT_STAGES; s++) begin
            w_src[s]     = r_st[s-1];
            w_src_v[s]   = r_v[s-1];
            w_src_sat[s] = r_sat[s-1];
        end
        for (int s = 0; s < rwg_pkg::ROOT_STAGES; s++) begin
            n_st[s] = w_src[s];
            for (int k = 0; k < rwg_pkg::ROOT_STEPS; k++) begin
                n_st[s] = rwg_pkg::root_step(n_st[s]);
            end
        end
    end

    always_comb begin
        w_rdy[LAST] = !r_v[LAST] || i_ready;
        for (int s = LAST - 1; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < rwg_pkg::ROOT_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= w_src_v[s];
                end
            end
        end
    end

    // advance payload with its valid bit
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < rwg_pkg::ROOT_STAGES; s++) begin
            if (w_rdy[s]) begin
                r_st[s]  <= n_st[s];
                r_sat[s] <= w_src_sat[s];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_grey  = r_sat[LAST] ? rwg_pkg::GREY_MAX : r_st[LAST].q;

`ifndef ASSERT_OFF
    a_rem_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_st[0].rem <= {2'b00, r_st[0].q, 1'b0}))
        else $error("root remainder exceeds bound in first stage");

    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (r_st[LAST].rem <= {2'b00, r_st[LAST].q, 1'b0}))
        else $error("root remainder exceeds bound in last stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_grey))
        else $error("stalled grey word lost or changed");
`endif

endmodule

// ===== rtl/rms_weighted_greyscale.sv =====
// An accepted pixel word passes stages 1 to 4 and then the root stages before its grey word leaves.
// Throughput: one word per cycle; a stall at the output fills bubbles first.
// Stages: squares, weighted products, two-step sum, four root stages.
// Reset (synchronous, active low) empties the pipeline and loads the
// BT.601 weights. Depends on rwg_pkg, rwg_if and rwg_root.
module rms_weighted_greyscale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rwg_pix_if.sink                    i_pix,
    rwg_grey_if.source                 o_grey,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rwg_pkg::APB_AW-1:0] paddr,
    input  logic [rwg_pkg::APB_DW-1:0] pwdata,
    output logic [rwg_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    logic [rwg_pkg::WEIGHT_W-1:0] r_weight_red;
    logic [rwg_pkg::WEIGHT_W-1:0] r_weight_green;
    logic [rwg_pkg::WEIGHT_W-1:0] r_weight_blue;

    logic                         w_wr;
    logic [1:0]                   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_red   <= rwg_pkg::RST_WEIGHT_RED;
            r_weight_green <= rwg_pkg::RST_WEIGHT_GREEN;
            r_weight_blue  <= rwg_pkg::RST_WEIGHT_BLUE;
        end else if (w_wr) begin
            case (w_idx)
                rwg_pkg::REG_WEIGHT_RED: begin
                    r_weight_red <= pwdata[rwg_pkg::WEIGHT_W-1:0];
                end
                rwg_pkg::REG_WEIGHT_GREEN: begin
                    r_weight_green <= pwdata[rwg_pkg::WEIGHT_W-1:0];
                end
                rwg_pkg::REG_WEIGHT_BLUE: begin
                    r_weight_blue <= pwdata[rwg_pkg::WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rwg_pkg::REG_WEIGHT_RED:   prdata = rwg_pkg::APB_DW'(r_weight_red);
            rwg_pkg::REG_WEIGHT_GREEN: prdata = rwg_pkg::APB_DW'(r_weight_green);
            rwg_pkg::REG_WEIGHT_BLUE:  prdata = rwg_pkg::APB_DW'(r_weight_blue);
            default:                   prdata = '0;
        endcase
    end

    // stage 1: squares
    logic                      r_v1;
    logic [rwg_pkg::SQ_W-1:0]  r_sq_r1;
    logic [rwg_pkg::SQ_W-1:0]  r_sq_g1;
    logic [rwg_pkg::SQ_W-1:0]  r_sq_b1;
    // stage 2: weighted products
    logic                       r_v2;
    logic [rwg_pkg::PROD_W-1:0] r_p_r2;
    logic [rwg_pkg::PROD_W-1:0] r_p_g2;
    logic [rwg_pkg::PROD_W-1:0] r_p_b2;
    // stage 3: partial sum
    logic                       r_v3;
    logic [rwg_pkg::PAIR_W-1:0] r_p_rg3;
    logic [rwg_pkg::PROD_W-1:0] r_p_b3;
    // stage 4: scaled sum and overflow flag
    logic                        r_v4;
    logic [rwg_pkg::VALUE_W-1:0] r_val4;
    logic                        r_sat4;

    logic                        w_rdy1;
    logic                        w_rdy2;
    logic                        w_rdy3;
    logic                        w_rdy4;
    logic                        w_root_ready;
    logic [rwg_pkg::SUM_W-1:0]   w_sum;

    assign w_rdy4 = !r_v4 || w_root_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign i_pix.ready = w_rdy1;

    assign w_sum = {1'b0, r_p_rg3} + {2'b00, r_p_b3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_pix.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_sq_r1 <= i_pix.red * i_pix.red;
            r_sq_g1 <= i_pix.green * i_pix.green;
            r_sq_b1 <= i_pix.blue * i_pix.blue;
        end
        if (w_rdy2) begin
            r_p_r2 <= r_weight_red * r_sq_r1;
            r_p_g2 <= r_weight_green * r_sq_g1;
            r_p_b2 <= r_weight_blue * r_sq_b1;
        end
        if (w_rdy3) begin
            r_p_rg3 <= {1'b0, r_p_r2} + {1'b0, r_p_g2};
            r_p_b3  <= r_p_b2;
        end
        if (w_rdy4) begin
            r_val4 <= w_sum[rwg_pkg::FRAC_W +: rwg_pkg::VALUE_W];
            r_sat4 <= |w_sum[rwg_pkg::SUM_W-1:rwg_pkg::FRAC_W + rwg_pkg::VALUE_W];
        end
    end

    rwg_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (w_root_ready),
        .i_value (r_val4),
        .i_sat   (r_sat4),
        .o_valid (o_grey.valid),
        .i_ready (o_grey.ready),
        .o_grey  (o_grey.grey)
    );

`ifndef ASSERT_OFF
    a_hold_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_rdy2 |=> r_v1 && $stable(r_sq_r1) && $stable(r_sq_g1)
            && $stable(r_sq_b1))
        else $error("stalled square word lost or changed");

    a_hold_stage4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !w_root_ready |=> r_v4 && $stable(r_val4) && $stable(r_sat4))
        else $error("stalled sum word lost or changed");

    a_weight_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && (w_idx == rwg_pkg::REG_WEIGHT_GREEN)
        |=> r_weight_green == $past(pwdata[rwg_pkg::WEIGHT_W-1:0]))
        else $error("green weight write not taken");
`endif

endmodule

// ===== test/rms_weighted_greyscale_tb.sv =====
// Self-checking testbench for rms_weighted_greyscale: RGB pixel words in, grey words out,
// weights written over APB between phases, each grey word checked against a local predictor.
// Depends on rwg_pkg, rwg_if and the block under test.
module rms_weighted_greyscale_tb;

    localparam int PIPE_LATENCY   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_AT    = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [rwg_pkg::APB_DW-1:0] WEIGHT_MASK =
        (rwg_pkg::APB_DW'(1) << rwg_pkg::WEIGHT_W) - 1;

    typedef struct packed {
        logic [rwg_pkg::PIX_W-1:0] red;
        logic [rwg_pkg::PIX_W-1:0] green;
        logic [rwg_pkg::PIX_W-1:0] blue;
    } t_pixel;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [rwg_pkg::APB_AW-1:0] paddr   = '0;
    logic [rwg_pkg::APB_DW-1:0] pwdata  = '0;
    logic [rwg_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    rwg_pix_if  pix_if ();
    rwg_grey_if grey_if ();

    rms_weighted_greyscale u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_grey  (grey_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [rwg_pkg::WEIGHT_W-1:0] w_red   = rwg_pkg::RST_WEIGHT_RED;
    logic [rwg_pkg::WEIGHT_W-1:0] w_green = rwg_pkg::RST_WEIGHT_GREEN;
    logic [rwg_pkg::WEIGHT_W-1:0] w_blue  = rwg_pkg::RST_WEIGHT_BLUE;

    t_pixel                    pixel_backlog[$];
    logic [rwg_pkg::PIX_W-1:0] grey_expected[$];
    t_pixel                    next_pix;
    logic [rwg_pkg::PIX_W-1:0] grey_want;

    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    int src_gap     = 0;
    int snk_gap     = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int greys_seen  = 0;
    int mismatches  = 0;
    int idle_cycles = 0;

    // floor(sqrt(weighted square sum)) >> 8, saturated
    function automatic logic [rwg_pkg::PIX_W-1:0] rms_grey(
        input logic [rwg_pkg::PIX_W-1:0] r,
        input logic [rwg_pkg::PIX_W-1:0] g,
        input logic [rwg_pkg::PIX_W-1:0] b);
        logic [39:0] wsum;
        logic [19:0] root;
        logic [19:0] trial;
        wsum = 40'(w_red) * 40'(r) * 40'(r)
             + 40'(w_green) * 40'(g) * 40'(g)
             + 40'(w_blue) * 40'(b) * 40'(b);
        root = '0;
        for (int k = 19; k >= 0; k--) begin
            trial = root | (20'd1 << k);
            if (40'(trial) * 40'(trial) <= wsum)
                root = trial;
        end
        root = root >> 8;
        return (root > 20'(rwg_pkg::GREY_MAX)) ? rwg_pkg::GREY_MAX
                                               : root[rwg_pkg::PIX_W-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rwg_pkg::PIX_W-1:0] random_channel();
        logic [rwg_pkg::PIX_W-1:0] corners[4] = '{8'd0, 8'd255, 8'd1, 8'd128};
        if ($urandom_range(0, 9) == 0)
            return corners[2'($urandom_range(0, 3))];
        return rwg_pkg::PIX_W'($urandom());
    endfunction

    task automatic push_pixel(input int r, input int g, input int b);
        t_pixel p;
        p.red   = rwg_pkg::PIX_W'(r);
        p.green = rwg_pkg::PIX_W'(g);
        p.blue  = rwg_pkg::PIX_W'(b);
        pixel_backlog = {pixel_backlog, p};
    endtask

    task automatic push_random(input int count);
        t_pixel p;
        for (int k = 0; k < count; k++) begin
            p.red   = random_channel();
            p.green = random_channel();
            p.blue  = random_channel();
            pixel_backlog = {pixel_backlog, p};
        end
    endtask

    // wait until every word is out and the pipeline has emptied
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pixel_backlog.size() != 0 || pix_if.valid || grey_expected.size() != 0);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [rwg_pkg::APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rwg_pkg::REG_WEIGHT_RED:   w_red   = data[rwg_pkg::WEIGHT_W-1:0];
            rwg_pkg::REG_WEIGHT_GREEN: w_green = data[rwg_pkg::WEIGHT_W-1:0];
            rwg_pkg::REG_WEIGHT_BLUE:  w_blue  = data[rwg_pkg::WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_weights(input int wr, input int wg, input int wb, input bit junk_high);
        logic [rwg_pkg::APB_DW-1:0] junk;
        junk = junk_high ? (rwg_pkg::APB_DW'($urandom()) & ~WEIGHT_MASK) : '0;
        write_reg(rwg_pkg::REG_WEIGHT_RED,   junk | rwg_pkg::APB_DW'(wr));
        write_reg(rwg_pkg::REG_WEIGHT_GREEN, junk | rwg_pkg::APB_DW'(wg));
        write_reg(rwg_pkg::REG_WEIGHT_BLUE,  junk | rwg_pkg::APB_DW'(wb));
        @(negedge i_clk);
    endtask

    // sender: hold the word until taken, insert random gaps between words when src_idle_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            src_gap      <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                grey_expected = {grey_expected,
                                 rms_grey(pix_if.red, pix_if.green, pix_if.blue)};
            if (!pix_if.valid || pix_if.ready) begin
                if (src_gap != 0) begin
                    pix_if.valid <= 1'b0;
                    src_gap      <= src_gap - 1;
                end else if (pixel_backlog.size() != 0) begin
                    next_pix      = pixel_backlog.pop_front();
                    pix_if.valid <= 1'b1;
                    pix_if.red   <= next_pix.red;
                    pix_if.green <= next_pix.green;
                    pix_if.blue  <= next_pix.blue;
                    src_gap      <= src_idle_on ? pick_gap() : 0;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off of the receiver once the stream is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && greys_seen >= PRESSURE_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grey_if.ready <= 1'b0;
            snk_gap       <= 0;
        end else if (hold_left != 0) begin
            grey_if.ready <= 1'b0;
        end else if (snk_gap != 0) begin
            grey_if.ready <= 1'b0;
            snk_gap       <= snk_gap - 1;
        end else begin
            grey_if.ready <= 1'b1;
            snk_gap       <= snk_idle_on ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && grey_if.valid && grey_if.ready) begin
            greys_seen <= greys_seen + 1;
            if (grey_expected.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("grey word %0d with nothing expected", grey_if.grey);
                mismatches <= mismatches + 1;
            end else begin
                grey_want = grey_expected.pop_front();
                if (grey_if.grey !== grey_want) begin
                    if (mismatches < MAX_REPORTS)
                        $display("grey mismatch at word %0d: expected %0d, got %0d",
                                 greys_seen, grey_want, grey_if.grey);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (grey_if.valid && grey_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rms_weighted_greyscale verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pix_if.valid  = 1'b0;
        pix_if.red    = '0;
        pix_if.green  = '0;
        pix_if.blue   = '0;
        grey_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset weights: extremes, single channels, bit patterns
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(255, 0, 0);
        push_pixel(0, 255, 0);
        push_pixel(0, 0, 255);
        push_pixel(1, 1, 1);
        push_pixel(128, 128, 128);
        push_pixel(16, 16, 16);
        push_pixel(8'hAA, 8'h55, 8'hAA);
        push_pixel(8'h55, 8'hAA, 8'h55);
        push_pixel(255, 255, 0);
        push_pixel(0, 255, 255);
        push_pixel(15, 240, 60);
        push_pixel(254, 1, 127);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        push_random(40);
        wait_idle();

        // sender flat out while the receiver holds off
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        push_random(250);
        wait_idle();

        set_weights(0, 0, 0, 1'b0);
        push_pixel(255, 255, 255);
        push_pixel(0, 0, 0);
        push_random(20);
        wait_idle();

        // weights summing past one: saturation
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        set_weights(65536, 65536, 65536, 1'b0);
        push_pixel(255, 255, 255);
        push_pixel(148, 148, 148);
        push_pixel(147, 147, 147);
        push_pixel(255, 0, 0);
        push_random(40);
        wait_idle();

        // drop bits above the weight width; ignore the unused register
        set_weights(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        write_reg(REG_UNUSED, 32'h0000_1234);
        @(negedge i_clk);
        push_pixel(255, 255, 255);
        push_pixel(1, 0, 0);
        push_random(20);
        wait_idle();

        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        set_weights(65536, 0, 0, 1'b0);
        push_pixel(200, 17, 99);
        push_random(20);
        wait_idle();

        for (int k = 0; k < 5; k++) begin
            src_idle_on = k[0];
            snk_idle_on = k[1] | k[2];
            set_weights($urandom_range(0, 65536), $urandom_range(0, 65536),
                        $urandom_range(0, 65536), k[0]);
            push_random(50);
            wait_idle();
        end

        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        set_weights(rwg_pkg::RST_WEIGHT_RED, rwg_pkg::RST_WEIGHT_GREEN,
                    rwg_pkg::RST_WEIGHT_BLUE, 1'b1);
        push_random(30);
        wait_idle();

        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
        if (mismatches == 0 && grey_expected.size() == 0)
            $display("rms_weighted_greyscale verification clean");
        else
            $display("rms_weighted_greyscale verification failed");
        $finish;
    end

endmodule
